[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs during reset.
`define AST_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/e2c_pkg.sv]
package e2c_pkg;

    localparam int unsigned InW    = 31;
    localparam int unsigned DaysW  = 15;
    localparam int unsigned YearW  = 11;
    localparam int unsigned InBytesW  = 32;
    localparam int unsigned OutBytesW = 40;

    localparam logic [InW-1:0]   SecPerDay  = 31'd86400;
    localparam logic [InW-1:0]   SecPerHour = 31'd3600;
    localparam logic [InW-1:0]   SecPerMin  = 31'd60;
    localparam logic [YearW-1:0] EpochYear  = 11'd1970;

    // Quotient bit counts minus one for each division pass
    localparam logic [3:0] DayTopBit  = 4'd14;
    localparam logic [3:0] HourTopBit = 4'd4;
    localparam logic [3:0] MinTopBit  = 4'd5;

    // Residues of the epoch year for the leap rule
    localparam logic [1:0] Epoch4   = 2'd2;
    localparam logic [6:0] Epoch100 = 7'd70;
    localparam logic [8:0] Epoch400 = 9'd370;

    localparam logic [3:0] MonthDec = 4'd11;
    localparam logic [3:0] MonthFeb = 4'd1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DAY  = 6'b000010,
        S_HOUR = 6'b000100,
        S_MIN  = 6'b001000,
        S_YEAR = 6'b010000,
        S_MON  = 6'b100000
    } t_state;

    // Compare-subtract result from the shared unit
    typedef struct packed {
        logic           ge;
        logic [InW-1:0] diff;
    } t_sub_res;

    // Days in a month, month counted from 0
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            MonthFeb:               len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/core/e2c_sub.sv]
module e2c_sub
    import e2c_pkg::*;
(
    input  logic [InW-1:0] i_a,
    input  logic [InW-1:0] i_b,
    output t_sub_res       o_res
);

    logic [InW:0] w_wide;

    // Subtract with one extra bit; no borrow means a >= b
    assign w_wide     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_wide[InW];
    assign o_res.diff = w_wide[InW-1:0];

endmodule

[rtl/core/epoch_seconds_to_calendar_top.sv]
// Channel   Dir  tdata fields (low bit up)                           tuser / tlast
// s_axis    in   epoch_seconds[30:0], zero pad to 32                  none
// m_axis    out  year[10:0] month[14:11] day_of_month[19:15]          none
//                hour[24:20] minute[30:25] second[36:31], pad to 40
//
// One item: 15 + 5 + 6 day/hour/minute division steps, one step per year since
// 1970 plus one (1 to 69), then 1 to 12 month steps, the last loading the output
// once the output register is free; all steps share the single compare-subtract
// unit; s_axis_tready is high only while the sequencer idles.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// A stalled result holds in the output register; a new beat is taken meanwhile.
module epoch_seconds_to_calendar_top
    import e2c_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [InBytesW-1:0]  i_s_axis_tdata,  // epoch_seconds[30:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OutBytesW-1:0] o_m_axis_tdata   // year, month, day_of_month,
                                                  // hour, minute, second
);

    t_state               r_state, n_state;
    logic [InW-1:0]       r_acc, n_acc;
    logic [DaysW-1:0]     r_q, n_q;
    logic [DaysW-1:0]     r_days, n_days;
    logic [4:0]           r_hour, n_hour;
    logic [5:0]           r_min, n_min;
    logic [5:0]           r_sec, n_sec;
    logic [YearW-1:0]     r_year, n_year;
    logic [1:0]           r_m4, n_m4;
    logic [6:0]           r_m100, n_m100;
    logic [8:0]           r_m400, n_m400;
    logic [3:0]           r_mon, n_mon;
    logic [3:0]           r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [OutBytesW-1:0] r_out_data, n_out_data;

    logic [InW-1:0]       w_b;
    t_sub_res             w_res;
    logic                 w_leap;
    logic                 w_out_free;
    logic                 w_take;
    logic                 w_done;

    assign w_leap = ((r_m4 == 2'd0) && (r_m100 != 7'd0)) || (r_m400 == 9'd0);
    assign w_out_free = ~r_out_valid | i_m_axis_tready;
    assign w_take = i_s_axis_tvalid & (r_state == S_IDLE);

    // Pick the operand for the shared unit
    always_comb begin
        unique case (r_state)
            S_DAY:   w_b = SecPerDay << r_cnt;
            S_HOUR:  w_b = SecPerHour << r_cnt;
            S_MIN:   w_b = SecPerMin << r_cnt;
            S_YEAR:  w_b = w_leap ? 31'd366 : 31'd365;
            S_MON:   w_b = {26'd0, month_len(r_mon, w_leap)};
            default: w_b = '0;
        endcase
    end

    e2c_sub u_sub (
        .i_a   (r_acc),
        .i_b   (w_b),
        .o_res (w_res)
    );

    // Month walk ends on a short remainder or at December, once the output is free
    assign w_done = (r_state == S_MON) && (~w_res.ge || (r_mon == MonthDec)) && w_out_free;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_q         = r_q;
        n_days      = r_days;
        n_hour      = r_hour;
        n_min       = r_min;
        n_sec       = r_sec;
        n_year      = r_year;
        n_m4        = r_m4;
        n_m100      = r_m100;
        n_m400      = r_m400;
        n_mon       = r_mon;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_acc   = i_s_axis_tdata[InW-1:0];
                    n_q     = '0;
                    n_cnt   = DayTopBit;
                    n_state = S_DAY;
                end
            end
            S_DAY, S_HOUR, S_MIN: begin
                // One restoring-division step
                if (w_res.ge) begin
                    n_acc = w_res.diff;
                end
                n_q   = {r_q[DaysW-2:0], w_res.ge};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_q = '0;
                    if (r_state == S_DAY) begin
                        n_days  = {r_q[DaysW-2:0], w_res.ge};
                        n_cnt   = HourTopBit;
                        n_state = S_HOUR;
                    end else if (r_state == S_HOUR) begin
                        n_hour  = {r_q[3:0], w_res.ge};
                        n_cnt   = MinTopBit;
                        n_state = S_MIN;
                    end else begin
                        n_min   = {r_q[4:0], w_res.ge};
                        n_sec   = w_res.ge ? w_res.diff[5:0] : r_acc[5:0];
                        n_acc   = {{(InW-DaysW){1'b0}}, r_days};
                        n_year  = EpochYear;
                        n_m4    = Epoch4;
                        n_m100  = Epoch100;
                        n_m400  = Epoch400;
                        n_state = S_YEAR;
                    end
                end
            end
            S_YEAR: begin
                // Take away a whole year while the day count allows it
                if (w_res.ge) begin
                    n_acc  = w_res.diff;
                    n_year = r_year + 11'd1;
                    n_m4   = r_m4 + 2'd1;
                    n_m100 = (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
                    n_m400 = (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
                end else begin
                    n_mon   = '0;
                    n_state = S_MON;
                end
            end
            S_MON: begin
                if (w_done) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'd0, r_sec, r_min, r_hour,
                                   r_acc[4:0] + 5'd1, r_mon + 4'd1, r_year};
                    n_state     = S_IDLE;
                end else if (w_res.ge && (r_mon != MonthDec)) begin
                    n_acc = w_res.diff;
                    n_mon = r_mon + 4'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_q        <= n_q;
        r_days     <= n_days;
        r_hour     <= n_hour;
        r_min      <= n_min;
        r_sec      <= n_sec;
        r_year     <= n_year;
        r_m4       <= n_m4;
        r_m100     <= n_m100;
        r_m400     <= n_m400;
        r_mon      <= n_mon;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

[rtl/core/e2c_checker.sv]
`include "assert_macros.svh"

module e2c_checker
    import e2c_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [InBytesW-1:0]  i_s_axis_tdata,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [OutBytesW-1:0] o_m_axis_tdata
);

    logic w_in_beat;
    logic w_month_ok;

    assign w_in_beat  = i_s_axis_tvalid & o_s_axis_tready;
    assign w_month_ok = (o_m_axis_tdata[14:11] != 4'd0) && (o_m_axis_tdata[14:11] <= 4'd12);

    // Busy right after an input beat
    `AST_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, !o_s_axis_tready, "ready after beat")
    // A stalled result holds
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")
    // Month field stays in range
    `AST_IMPL(a_month_range, i_clk, i_rst_n, o_m_axis_tvalid, w_month_ok, "month out of range")
    // A new result appears only as a busy period ends
    `AST_IMPL(a_result_from_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready) && !$past(i_s_axis_tdata[31]) || !$past(o_s_axis_tready), "result without work")
    // Reset drops output valid
    `AST_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_m_axis_tvalid, "valid after reset")

endmodule

bind epoch_seconds_to_calendar_top e2c_checker u_e2c_checker (.*);
